// ----- hw/rtl/sdbl_pkg.sv -----
`default_nettype none
package sdbl_pkg;

  localparam int ROW_W  = 6;
  localparam int COL_W  = 6;
  localparam int CELL_W = ROW_W + COL_W;
  localparam int ALT_W  = 16;
  localparam int LBL_W  = 12;
  localparam int DIM_W  = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CELLS  = 1 << CELL_W;
  localparam int MAX_ROWS = 1 << ROW_W;
  localparam int MAX_COLS = 1 << COL_W;

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_RUN  = 2'd1,
    REQ_READ = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OUTSIDE   = 2'd1,
    STAT_NOT_READY = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEIGHT = 1'b0,
    CFG_WIDTH  = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ_WAIT,
    ST_D_RD0,
    ST_D_RD1,
    ST_D_RD2,
    ST_D_RD3,
    ST_D_RD4,
    ST_D_WR,
    ST_A_RD,
    ST_A_CHK,
    ST_B_RD,
    ST_B_CHK,
    ST_L_RD,
    ST_L_SINK,
    ST_L_CHK
  } state_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [ALT_W-1:0] altitude;
  } req_t;

  typedef struct packed {
    logic [LBL_W-1:0] label;
    logic [1:0]       status;
  } result_t;

  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
  } grid_t;

  typedef struct packed {
    logic              valid;
    logic [CELL_W-1:0] sink;
    logic [CELL_W-1:0] nxt;
  } path_word_t;

  typedef struct packed {
    logic             valid;
    logic [LBL_W-1:0] label;
  } basin_word_t;

  typedef struct packed {
    logic              we;
    logic [CELL_W-1:0] addr;
    logic [ALT_W-1:0]  wdata;
  } alt_port_t;

  typedef struct packed {
    logic              we;
    logic [CELL_W-1:0] addr;
    path_word_t        wdata;
  } path_port_t;

  typedef struct packed {
    logic              we;
    logic [CELL_W-1:0] addr;
    basin_word_t       wdata;
  } basin_port_t;

  typedef struct packed {
    logic              we;
    logic [CELL_W-1:0] addr;
    logic [LBL_W-1:0]  wdata;
  } label_port_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sdbl_ram.sv -----
`default_nettype none
module sdbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/sdbl_ctrl.sv -----
`default_nettype none
module sdbl_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire sdbl_pkg::req_t         req,
  input  wire sdbl_pkg::grid_t        grid,
  input  wire logic                   cfg_write,
  output      logic                   busy,
  output      logic                   done,
  output      sdbl_pkg::result_t      result,
  output      sdbl_pkg::alt_port_t    alt_port,
  input  wire logic [sdbl_pkg::ALT_W-1:0] alt_rd,
  output      sdbl_pkg::path_port_t   path_port,
  input  wire sdbl_pkg::path_word_t   path_rd,
  output      sdbl_pkg::basin_port_t  basin_port,
  input  wire sdbl_pkg::basin_word_t  basin_rd,
  output      sdbl_pkg::label_port_t  label_port,
  input  wire logic [sdbl_pkg::LBL_W-1:0] label_rd
);

  sdbl_pkg::state_e state, state_next;

  logic [sdbl_pkg::ROW_W-1:0]  row;
  logic [sdbl_pkg::COL_W-1:0]  col;
  logic [sdbl_pkg::CELL_W-1:0] cur;
  logic [sdbl_pkg::CELL_W-1:0] sink;
  logic [sdbl_pkg::ALT_W-1:0]  best_alt;
  logic [sdbl_pkg::CELL_W-1:0] best_idx;
  logic [sdbl_pkg::LBL_W-1:0]  next_label;
  logic                        labels_ready;
  logic                        labels_ready_next;
  logic                        done_next;

  logic [sdbl_pkg::CELL_W-1:0] scan_idx;
  logic [sdbl_pkg::CELL_W-1:0] req_cell;
  logic [sdbl_pkg::CELL_W-1:0] best_final;
  logic [sdbl_pkg::CELL_W-1:0] cell_adv;
  logic [sdbl_pkg::ROW_W-1:0]  row_adv;
  logic [sdbl_pkg::COL_W-1:0]  col_adv;
  logic [sdbl_pkg::LBL_W-1:0]  lbl_sel;
  logic                        last_col;
  logic                        last_cell;
  logic                        has_east;
  logic                        has_south;
  logic                        req_inside;
  logic                        accept;
  logic                        is_load;
  logic                        is_run;
  logic                        is_read;

  localparam logic [sdbl_pkg::CELL_W-1:0] ROW_STEP = sdbl_pkg::CELL_W'(sdbl_pkg::MAX_COLS);
  localparam logic [sdbl_pkg::CELL_W-1:0] ONE_CELL = sdbl_pkg::CELL_W'(1);

  assign scan_idx = {row, col};
  assign req_cell = {req.row, req.col};
  assign accept   = start && (state == sdbl_pkg::ST_IDLE);
  assign busy     = (state != sdbl_pkg::ST_IDLE);
  assign is_load  = (req.req_type == sdbl_pkg::REQ_LOAD);
  assign is_run   = (req.req_type == sdbl_pkg::REQ_RUN);
  assign is_read  = (req.req_type == sdbl_pkg::REQ_READ);

  assign req_inside = ({1'b0, req.row} < grid.rows) && ({1'b0, req.col} < grid.cols);

  assign last_col  = ({1'b0, col} == grid.cols - 7'd1);
  assign last_cell = last_col && ({1'b0, row} == grid.rows - 7'd1);
  assign has_east  = ({1'b0, col} + 7'd1 < grid.cols);
  assign has_south = ({1'b0, row} + 7'd1 < grid.rows);

  assign col_adv  = last_col ? '0 : col + 1'b1;
  assign row_adv  = last_col ? row + 1'b1 : row;
  assign cell_adv = {row_adv, col_adv};

  // south neighbor is the last candidate; compare it against the running best
  assign best_final = (has_south && (alt_rd < best_alt)) ? scan_idx + ROW_STEP : best_idx;
  assign lbl_sel    = basin_rd.valid ? basin_rd.label : next_label;

  // strobe a result for every request but a run or a ready read, which answer later
  assign done_next = (accept && !is_run && !(is_read && req_inside && labels_ready)) ||
                     (state == sdbl_pkg::ST_READ_WAIT) ||
                     ((state == sdbl_pkg::ST_L_CHK) && last_cell);

  always_comb begin
    labels_ready_next = labels_ready;
    if ((state == sdbl_pkg::ST_L_CHK) && last_cell) begin
      labels_ready_next = 1'b1;
    end
    // drop stale labels on an in-grid load or a config write
    if ((accept && is_load && req_inside) || cfg_write) begin
      labels_ready_next = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sdbl_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_run) begin
            state_next = sdbl_pkg::ST_D_RD0;
          end else if (is_read && req_inside && labels_ready) begin
            state_next = sdbl_pkg::ST_READ_WAIT;
          end
        end
      end
      sdbl_pkg::ST_READ_WAIT: state_next = sdbl_pkg::ST_IDLE;
      sdbl_pkg::ST_D_RD0: state_next = sdbl_pkg::ST_D_RD1;
      sdbl_pkg::ST_D_RD1: state_next = sdbl_pkg::ST_D_RD2;
      sdbl_pkg::ST_D_RD2: state_next = sdbl_pkg::ST_D_RD3;
      sdbl_pkg::ST_D_RD3: state_next = sdbl_pkg::ST_D_RD4;
      sdbl_pkg::ST_D_RD4: state_next = sdbl_pkg::ST_D_WR;
      sdbl_pkg::ST_D_WR: state_next = last_cell ? sdbl_pkg::ST_A_RD : sdbl_pkg::ST_D_RD0;
      sdbl_pkg::ST_A_RD: state_next = sdbl_pkg::ST_A_CHK;
      sdbl_pkg::ST_A_CHK: begin
        if (path_rd.valid || (path_rd.nxt == cur)) begin
          state_next = sdbl_pkg::ST_B_RD;
        end else begin
          state_next = sdbl_pkg::ST_A_RD;
        end
      end
      sdbl_pkg::ST_B_RD: state_next = sdbl_pkg::ST_B_CHK;
      sdbl_pkg::ST_B_CHK: begin
        if (!path_rd.valid) begin
          state_next = sdbl_pkg::ST_B_RD;
        end else if (last_cell) begin
          state_next = sdbl_pkg::ST_L_RD;
        end else begin
          state_next = sdbl_pkg::ST_A_RD;
        end
      end
      sdbl_pkg::ST_L_RD: state_next = sdbl_pkg::ST_L_SINK;
      sdbl_pkg::ST_L_SINK: state_next = sdbl_pkg::ST_L_CHK;
      sdbl_pkg::ST_L_CHK: state_next = last_cell ? sdbl_pkg::ST_IDLE : sdbl_pkg::ST_L_RD;
      default: state_next = sdbl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    alt_port   = '0;
    path_port  = '0;
    basin_port = '0;
    label_port = '0;
    unique case (state)
      sdbl_pkg::ST_IDLE: begin
        alt_port.addr   = req_cell;
        alt_port.wdata  = req.altitude;
        alt_port.we     = accept && is_load && req_inside;
        label_port.addr = req_cell;
      end
      sdbl_pkg::ST_D_RD0: alt_port.addr = scan_idx;
      sdbl_pkg::ST_D_RD1: alt_port.addr = scan_idx - ROW_STEP;
      sdbl_pkg::ST_D_RD2: alt_port.addr = scan_idx - ONE_CELL;
      sdbl_pkg::ST_D_RD3: alt_port.addr = scan_idx + ONE_CELL;
      sdbl_pkg::ST_D_RD4: alt_port.addr = scan_idx + ROW_STEP;
      sdbl_pkg::ST_D_WR: begin
        // store the descent pointer and drop both valid marks for this cell
        path_port.we        = 1'b1;
        path_port.addr      = scan_idx;
        path_port.wdata.nxt = best_final;
        basin_port.we       = 1'b1;
        basin_port.addr     = scan_idx;
      end
      sdbl_pkg::ST_A_RD: path_port.addr = cur;
      sdbl_pkg::ST_A_CHK: begin
        path_port.addr = cur;
        if (!path_rd.valid && (path_rd.nxt == cur)) begin
          path_port.we    = 1'b1;
          path_port.wdata = '{valid: 1'b1, sink: cur, nxt: cur};
        end
      end
      sdbl_pkg::ST_B_RD: path_port.addr = cur;
      sdbl_pkg::ST_B_CHK: begin
        path_port.addr = cur;
        if (!path_rd.valid) begin
          path_port.we    = 1'b1;
          path_port.wdata = '{valid: 1'b1, sink: sink, nxt: path_rd.nxt};
        end
      end
      sdbl_pkg::ST_L_RD: path_port.addr = scan_idx;
      sdbl_pkg::ST_L_SINK: basin_port.addr = path_rd.sink;
      sdbl_pkg::ST_L_CHK: begin
        basin_port.addr = sink;
        if (!basin_rd.valid) begin
          basin_port.we    = 1'b1;
          basin_port.wdata = '{valid: 1'b1, label: next_label};
        end
        label_port.we    = 1'b1;
        label_port.addr  = scan_idx;
        label_port.wdata = lbl_sel;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sdbl_pkg::ST_IDLE;
      labels_ready <= 1'b0;
      next_label   <= '0;
      row          <= '0;
      col          <= '0;
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      done         <= done_next;
      labels_ready <= labels_ready_next;
      unique case (state)
        sdbl_pkg::ST_IDLE: begin
          if (accept) begin
            if (is_run) begin
              row        <= '0;
              col        <= '0;
              next_label <= '0;
            end else if (is_load || is_read) begin
              if (!req_inside) begin
                result <= '{label: '0, status: sdbl_pkg::STAT_OUTSIDE};
              end else if (is_load) begin
                result <= '{label: '0, status: sdbl_pkg::STAT_OK};
              end else if (!labels_ready) begin
                result <= '{label: '0, status: sdbl_pkg::STAT_NOT_READY};
              end
            end else begin
              result <= '{label: '0, status: sdbl_pkg::STAT_OK};
            end
          end
        end
        sdbl_pkg::ST_READ_WAIT: begin
          result <= '{label: label_rd, status: sdbl_pkg::STAT_OK};
        end
        sdbl_pkg::ST_D_RD1: begin
          best_alt <= alt_rd;
          best_idx <= scan_idx;
        end
        sdbl_pkg::ST_D_RD2: begin
          if ((row != '0) && (alt_rd < best_alt)) begin
            best_alt <= alt_rd;
            best_idx <= scan_idx - ROW_STEP;
          end
        end
        sdbl_pkg::ST_D_RD3: begin
          if ((col != '0) && (alt_rd < best_alt)) begin
            best_alt <= alt_rd;
            best_idx <= scan_idx - ONE_CELL;
          end
        end
        sdbl_pkg::ST_D_RD4: begin
          if (has_east && (alt_rd < best_alt)) begin
            best_alt <= alt_rd;
            best_idx <= scan_idx + ONE_CELL;
          end
        end
        sdbl_pkg::ST_D_WR: begin
          if (last_cell) begin
            row <= '0;
            col <= '0;
            cur <= '0;
          end else begin
            row <= row_adv;
            col <= col_adv;
          end
        end
        sdbl_pkg::ST_A_CHK: begin
          if (path_rd.valid) begin
            sink <= path_rd.sink;
            cur  <= scan_idx;
          end else if (path_rd.nxt == cur) begin
            sink <= cur;
            cur  <= scan_idx;
          end else begin
            cur <= path_rd.nxt;
          end
        end
        sdbl_pkg::ST_B_CHK: begin
          if (!path_rd.valid) begin
            cur <= path_rd.nxt;
          end else if (last_cell) begin
            row <= '0;
            col <= '0;
          end else begin
            row <= row_adv;
            col <= col_adv;
            cur <= cell_adv;
          end
        end
        sdbl_pkg::ST_L_SINK: sink <= path_rd.sink;
        sdbl_pkg::ST_L_CHK: begin
          if (!basin_rd.valid) begin
            next_label <= next_label + 1'b1;
          end
          if (last_cell) begin
            result <= '{label: '0, status: sdbl_pkg::STAT_OK};
          end else begin
            row <= row_adv;
            col <= col_adv;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/steepest_descent_basin_labeler.sv -----
`default_nettype none
// Load, out-of-grid, unknown and not-ready requests: result strobed in the cycle after start.
// Read request: result strobed after the registered label memory read and the read-wait state.
// Run request: a descent sweep over the altitude memory port, then the two walks over the
// path memory, then labeling of every cell; busy throughout.
// Results are strobed on done for one cycle; the receiver cannot stall.
// Synchronous reset: idle, labels not ready, grid 64 x 64; memories keep their contents.
module steepest_descent_basin_labeler (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire sdbl_pkg::req_t                      req,
  output      logic                                busy,
  output      logic                                done,
  output      sdbl_pkg::result_t                   result,
  input  wire logic                                cfg_we,
  input  wire logic [sdbl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sdbl_pkg::DIM_W-1:0]          cfg_data
);

  logic [sdbl_pkg::DIM_W-1:0] grid_height;
  logic [sdbl_pkg::DIM_W-1:0] grid_width;
  sdbl_pkg::grid_t            grid;

  sdbl_pkg::alt_port_t   alt_port;
  sdbl_pkg::path_port_t  path_port;
  sdbl_pkg::basin_port_t basin_port;
  sdbl_pkg::label_port_t label_port;
  logic [sdbl_pkg::ALT_W-1:0] alt_rd;
  sdbl_pkg::path_word_t       path_rd;
  sdbl_pkg::basin_word_t      basin_rd;
  logic [sdbl_pkg::LBL_W-1:0] label_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_height <= sdbl_pkg::DIM_W'(sdbl_pkg::MAX_ROWS);
      grid_width  <= sdbl_pkg::DIM_W'(sdbl_pkg::MAX_COLS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        sdbl_pkg::CFG_HEIGHT: grid_height <= cfg_data;
        sdbl_pkg::CFG_WIDTH:  grid_width  <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp to 1..max
  always_comb begin
    grid.rows = grid_height;
    grid.cols = grid_width;
    if (grid_height == '0) begin
      grid.rows = sdbl_pkg::DIM_W'(1);
    end else if (grid_height > sdbl_pkg::DIM_W'(sdbl_pkg::MAX_ROWS)) begin
      grid.rows = sdbl_pkg::DIM_W'(sdbl_pkg::MAX_ROWS);
    end
    if (grid_width == '0) begin
      grid.cols = sdbl_pkg::DIM_W'(1);
    end else if (grid_width > sdbl_pkg::DIM_W'(sdbl_pkg::MAX_COLS)) begin
      grid.cols = sdbl_pkg::DIM_W'(sdbl_pkg::MAX_COLS);
    end
  end

  sdbl_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .req        (req),
    .grid       (grid),
    .cfg_write  (cfg_we),
    .busy       (busy),
    .done       (done),
    .result     (result),
    .alt_port   (alt_port),
    .alt_rd     (alt_rd),
    .path_port  (path_port),
    .path_rd    (path_rd),
    .basin_port (basin_port),
    .basin_rd   (basin_rd),
    .label_port (label_port),
    .label_rd   (label_rd)
  );

  sdbl_ram #(.WIDTH(sdbl_pkg::ALT_W), .DEPTH(sdbl_pkg::CELLS)) u_alt_ram (
    .clk   (clk),
    .we    (alt_port.we),
    .addr  (alt_port.addr),
    .wdata (alt_port.wdata),
    .rdata (alt_rd)
  );

  sdbl_ram #(.WIDTH($bits(sdbl_pkg::path_word_t)), .DEPTH(sdbl_pkg::CELLS)) u_path_ram (
    .clk   (clk),
    .we    (path_port.we),
    .addr  (path_port.addr),
    .wdata (path_port.wdata),
    .rdata (path_rd)
  );

  sdbl_ram #(.WIDTH($bits(sdbl_pkg::basin_word_t)), .DEPTH(sdbl_pkg::CELLS)) u_basin_ram (
    .clk   (clk),
    .we    (basin_port.we),
    .addr  (basin_port.addr),
    .wdata (basin_port.wdata),
    .rdata (basin_rd)
  );

  sdbl_ram #(.WIDTH(sdbl_pkg::LBL_W), .DEPTH(sdbl_pkg::CELLS)) u_label_ram (
    .clk   (clk),
    .we    (label_port.we),
    .addr  (label_port.addr),
    .wdata (label_port.wdata),
    .rdata (label_rd)
  );

endmodule
`default_nettype wire
